### src/nvs_pkg.sv
// Shared types and constants for the nearest vertex search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package nvs_pkg;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int NORMAL_W = 32;
    localparam int DIST_W   = 27;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W + 1;
    localparam int SUM_W    = SQ_W + 1;

    // Stream word widths
    localparam int IN_DATA_W  = 6 * COORD_W + NORMAL_W;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USED_W = 2 + NORMAL_W + DIST_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LIMIT_SQ = 2'd0;
    localparam t_cfg_idx CFG_CLOSE_SQ = 2'd1;

    // Reset values of the registers and search state
    localparam logic [DIST_W-1:0] LIMIT_SQ_RST = 27'd67108864;
    localparam logic [DIST_W-1:0] CLOSE_SQ_RST = 27'd65536;
    localparam logic [DIST_W-1:0] DIST_NONE    = {DIST_W{1'b1}};

    // Squared deltas of one candidate, passed from the distance stage
    typedef struct packed {
        logic [SQ_W-1:0]     sq_x;
        logic [SQ_W-1:0]     sq_y;
        logic [SQ_W-1:0]     sq_z;
        logic [NORMAL_W-1:0] normal;
        logic                last;
    } t_sq_word;

endpackage

`default_nettype wire

### src/nvs_dist.sv
// Input register and squared-delta stage of the nearest vertex search.
// Depends on nvs_pkg.
`default_nettype none

module nvs_dist
    import nvs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IN_DATA_W-1:0] i_data,
    input  wire logic                 i_last,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_sq_word                  o_sq
);

    logic                        r_s1_valid;
    logic signed [COORD_W-1:0]   r_qx, r_qy, r_qz, r_cx, r_cy, r_cz;
    logic [NORMAL_W-1:0]         r_normal;
    logic                        r_last;
    logic                        r_s2_valid;
    t_sq_word                    r_sq;

    logic                        s2_adv, s1_adv;
    logic signed [DIFF_W-1:0]    dx, dy, dz;
    logic signed [2*DIFF_W-1:0]  px, py, pz;

    // Advance a stage when it is empty or its word moves on
    assign s2_adv  = !r_s2_valid || i_ready;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign o_ready = s1_adv;

    // Signed deltas and their squares
    always_comb begin
        dx = DIFF_W'(r_cx) - DIFF_W'(r_qx);
        dy = DIFF_W'(r_cy) - DIFF_W'(r_qy);
        dz = DIFF_W'(r_cz) - DIFF_W'(r_qz);
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_qx     <= i_data[0*COORD_W +: COORD_W];
            r_qy     <= i_data[1*COORD_W +: COORD_W];
            r_qz     <= i_data[2*COORD_W +: COORD_W];
            r_cx     <= i_data[3*COORD_W +: COORD_W];
            r_cy     <= i_data[4*COORD_W +: COORD_W];
            r_cz     <= i_data[5*COORD_W +: COORD_W];
            r_normal <= i_data[6*COORD_W +: NORMAL_W];
            r_last   <= i_last;
        end
    end

    // Register the squares; each is non-negative and fits SQ_W bits
    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_sq.sq_x   <= px[SQ_W-1:0];
            r_sq.sq_y   <= py[SQ_W-1:0];
            r_sq.sq_z   <= pz[SQ_W-1:0];
            r_sq.normal <= r_normal;
            r_sq.last   <= r_last;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_sq    = r_sq;

endmodule

`default_nettype wire

### src/nvs_track.sv
// Running-minimum tracker and result register of the nearest vertex search.
// Depends on nvs_pkg.
`default_nettype none

module nvs_track
    import nvs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_sq_word              i_sq,
    input  wire logic [DIST_W-1:0]     i_limit_sq,
    input  wire logic [DIST_W-1:0]     i_close_sq,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_DATA_W-1:0]      o_data
);

    logic [DIST_W-1:0]     r_best, n_best;
    logic [NORMAL_W-1:0]   r_normal, n_normal;
    logic                  r_have, n_have;
    logic                  r_done, n_done;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_USED_W-1:0] r_out;

    logic [SUM_W-1:0]      sum_sq;
    logic                  fire, take, emit;

    // Hold a closing word while the result slot is occupied and not being taken
    assign o_ready = !i_sq.last || !r_out_valid || i_ready;
    assign fire    = i_valid && o_ready;
    assign emit    = fire && i_sq.last;

    // Distance and update of the best candidate
    always_comb begin
        sum_sq = SUM_W'(i_sq.sq_x) + SUM_W'(i_sq.sq_y) + SUM_W'(i_sq.sq_z);
        take = !r_done && (sum_sq < SUM_W'(i_limit_sq)) && (sum_sq < SUM_W'(r_best));
        n_best   = r_best;
        n_normal = r_normal;
        n_have   = r_have;
        n_done   = r_done;
        if (fire && take) begin
            n_best   = sum_sq[DIST_W-1:0];
            n_normal = i_sq.normal;
            n_have   = 1'b1;
            n_done   = sum_sq < SUM_W'(i_close_sq);
        end
        n_out_valid = emit || (r_out_valid && !i_ready);
    end

    // Search state; clear after the closing word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= DIST_NONE;
            r_normal    <= '0;
            r_have      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (emit) begin
                r_best   <= DIST_NONE;
                r_normal <= '0;
                r_have   <= 1'b0;
                r_done   <= 1'b0;
            end else begin
                r_best   <= n_best;
                r_normal <= n_normal;
                r_have   <= n_have;
                r_done   <= n_done;
            end
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= {n_have ? n_best : {DIST_W{1'b0}},
                      n_have ? n_normal : {NORMAL_W{1'b0}},
                      n_done, n_have};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = OUT_DATA_W'(r_out);

endmodule

`default_nettype wire

### src/nearest_vertex_search.sv
// Nearest vertex search top level: distance stage, tracker, register file.
// A closing word passes the input register, the squared-delta register and the result register.
// Throughput: one candidate per cycle unless a closing word waits on a held result slot.
// Reset: synchronous, active low; clears the search and restores both limits.
// Depends on nvs_pkg, nvs_dist and nvs_track.
`default_nettype none

module nearest_vertex_search
    import nvs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Candidate stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, lowest bit up: query_x, query_y, query_z, candidate_x,
    // candidate_y, candidate_z, candidate_normal
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, lowest bit up: found, stopped_early, best_normal,
    // best_dist_sq, zero padding
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // Configuration writes
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [DIST_W-1:0]     i_cfg_wr_data
);

    logic [DIST_W-1:0] r_limit_sq;
    logic [DIST_W-1:0] r_close_sq;
    logic              sq_valid;
    logic              sq_ready;
    t_sq_word          sq_word;

    // Register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_sq <= LIMIT_SQ_RST;
            r_close_sq <= CLOSE_SQ_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_LIMIT_SQ: r_limit_sq <= i_cfg_wr_data;
                CFG_CLOSE_SQ: r_close_sq <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    nvs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_sq    (sq_word)
    );

    nvs_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (sq_valid),
        .o_ready    (sq_ready),
        .i_sq       (sq_word),
        .i_limit_sq (r_limit_sq),
        .i_close_sq (r_close_sq),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire

### src/nvs_checker.sv
// Port-level checks for the nearest vertex search, bound to the top level.
// Depends on nvs_pkg.
`default_nettype none

module nvs_checker
    import nvs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // No result word straight after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word shown after reset");

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // Early stop implies a match
    a_stop_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("stopped_early without found");

    // No match gives zero normal, distance and padding
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_DATA_W-1:2] == '0)
        else $error("empty result carries data");

endmodule

bind nearest_vertex_search nvs_checker u_nvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
